// ----- rtl/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, constants and the elaborated sine table for the three-phase
// sinusoidal commutation block.
// ----------------------------------------------------------------------------
package scm_pkg;

  // Table and encoder geometry (table size and 2*encoder counts are powers of two)
  localparam int TABLE_SIZE     = 256;
  localparam int ENCODER_COUNTS = 4096;
  localparam int SINE_AMPLITUDE = 1024;

  localparam int IDX_W     = $clog2(TABLE_SIZE);
  localparam int IDX_SHIFT = $clog2(2 * ENCODER_COUNTS);
  localparam int AMP_SHIFT = $clog2(SINE_AMPLITUDE);
  localparam int SINE_W    = $clog2(SINE_AMPLITUDE + 1) + 1;

  // Field widths
  localparam int TORQUE_W = 17;
  localparam int ANGLE_W  = 12;
  localparam int POLE_W   = 7;
  localparam int FS_W     = 16;
  localparam int DUTY_W   = 16;
  localparam int AP_W     = ANGLE_W + POLE_W;
  localparam int PROD_W   = SINE_W - 1 + FS_W;
  localparam int QUOT_W   = PROD_W - AMP_SHIFT;

  // Phase offsets in table entries
  localparam logic [IDX_W-1:0] OFFS_POS = IDX_W'(TABLE_SIZE - (3 * TABLE_SIZE) / 4);
  localparam logic [IDX_W-1:0] OFFS_NEG = IDX_W'((3 * TABLE_SIZE) / 4);
  localparam logic [IDX_W-1:0] PHASE_B  = IDX_W'(TABLE_SIZE / 3);
  localparam logic [IDX_W-1:0] PHASE_C  = IDX_W'(2 * (TABLE_SIZE / 3));

  // Configuration register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'd1;
  localparam logic [POLE_W-1:0]    POLE_RESET     = 7'd14;
  localparam logic [FS_W-1:0]      FS_RESET       = 16'd1000;

  // Item payloads
  typedef struct packed {
    logic signed [TORQUE_W-1:0] torque_command;
    logic [ANGLE_W-1:0]         shaft_angle;
    logic                       motor_select;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_first;
    logic [DUTY_W-1:0] duty_second;
    logic [DUTY_W-1:0] duty_third;
  } out_item_t;

  // Front end to phase lanes
  typedef struct packed {
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic [IDX_W-1:0] addr_c;
    logic [FS_W-1:0]  mag;
    logic             sel;
  } ph_req_t;

  // --------------------------------------------------------------------------
  // Sine table, built at elaboration with a Q62 fixed-point series
  // --------------------------------------------------------------------------
  localparam logic [63:0] HALF_PI_Q62  = 64'h6487ED5110B4611A;
  localparam logic [63:0] LOW32        = 64'hFFFFFFFF;
  localparam logic [63:0] TABLE_SIZE_Q = 64'(TABLE_SIZE);
  localparam logic [63:0] AMP_Q        = 64'(SINE_AMPLITUDE);
  localparam logic [63:0] AMP_HALF_Q   = 64'((SINE_AMPLITUDE + 1) / 2);

  typedef logic signed [SINE_W-1:0] sine_rom_t [TABLE_SIZE];

  // (a * b) >> 62 for Q62 operands
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = a & LOW32;
    ah  = a >> 32;
    bl  = b & LOW32;
    bh  = b >> 32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + (lh & LOW32) + (hl & LOW32);
    lo  = (ll & LOW32) | (mid << 32);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // Restoring shift-subtract quotient, table build only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Rounded amplitude * sin(m / TABLE_SIZE * pi / 2)
  function automatic logic [63:0] quarter_sine(input logic [63:0] m);
    logic [63:0] x, x2, term, sum, sh, sl, low, dv, res;
    res = '0;
    if (m == 0) begin
      res = '0;
    end else if (3 * m == TABLE_SIZE_Q) begin
      // sine of one half is taken exactly
      res = AMP_HALF_Q;
    end else begin
      x    = (HALF_PI_Q62 / TABLE_SIZE_Q) * m + ((HALF_PI_Q62 % TABLE_SIZE_Q) * m) / TABLE_SIZE_Q;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int unsigned k = 1; k < 40; k++) begin
        if (term != 0) begin
          dv   = 64'((2 * k) * (2 * k + 1));
          term = udiv64(mul_q62(term, x2), dv);
          if (k[0]) sum = sum - term;
          else      sum = sum + term;
        end
      end
      sh  = sum >> 32;
      sl  = sum & LOW32;
      low = AMP_Q * sl + (64'd1 << 61);
      res = (AMP_Q * sh + (low >> 32)) >> 30;
    end
    return res;
  endfunction

  // Signed table entry at index i
  function automatic logic signed [SINE_W-1:0] sine_value(input logic [63:0] i);
    logic [63:0] t, q, r, m, v;
    t = 4 * i;
    q = (t / TABLE_SIZE_Q) & 64'd3;
    r = t % TABLE_SIZE_Q;
    m = q[0] ? TABLE_SIZE_Q - r : r;
    v = quarter_sine(m);
    return (q >= 2) ? -$signed(SINE_W'(v)) : $signed(SINE_W'(v));
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      rom[i] = sine_value(64'(i));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- rtl/sine_commutation_three_phase.sv -----
// ----------------------------------------------------------------------------
// sine_commutation_three_phase
// Sinusoidal three-phase commutation: torque command and rotor angle in,
// three PWM duties out.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken on every clock with start high (busy
// never rises). Its three duties sit on out_data, flagged by out_valid, for
// a single cycle, after passing the five register stages: torque clip and
// angle multiply, index and phase offsets, sine table read, magnitude
// multiply, and divide/clip. Results cannot be held off, so the receiver
// must take out_data whenever out_valid is high. cfg_ready is always high,
// but write configuration only while no item is in flight: the full scale
// register is read again in the last stage.
// ----------------------------------------------------------------------------
module sine_commutation_three_phase (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  scm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  output scm_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LANE_LAT = 3;
  localparam int LATENCY  = 5;

  logic [scm_pkg::POLE_W-1:0]  pole_count_r;
  logic [scm_pkg::FS_W-1:0]    full_scale_r;

  logic                        accept;
  logic                        req_valid;
  scm_pkg::ph_req_t            req;

  logic [LANE_LAT-1:0]         v_r;
  logic [LANE_LAT-1:0]         sel_r;

  logic [scm_pkg::DUTY_W-1:0]  duty_a;
  logic [scm_pkg::DUTY_W-1:0]  duty_b;
  logic [scm_pkg::DUTY_W-1:0]  duty_c;

  // Handshakes: the pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_count_r <= scm_pkg::POLE_RESET;
      full_scale_r <= scm_pkg::FS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scm_pkg::CFG_POLE_COUNT: pole_count_r <= cfg_data[scm_pkg::POLE_W-1:0];
        scm_pkg::CFG_FULL_SCALE: full_scale_r <= cfg_data[scm_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Torque clip and table addresses
  scm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_item    (in_data),
    .pole_count (pole_count_r),
    .full_scale (full_scale_r),
    .req_valid  (req_valid),
    .req        (req)
  );

  // Phase lanes
  scm_phase u_phase_a (
    .clk        (clk),
    .addr       (req.addr_a),
    .mag        (req.mag),
    .full_scale (full_scale_r),
    .duty       (duty_a)
  );

  scm_phase u_phase_b (
    .clk        (clk),
    .addr       (req.addr_b),
    .mag        (req.mag),
    .full_scale (full_scale_r),
    .duty       (duty_b)
  );

  scm_phase u_phase_c (
    .clk        (clk),
    .addr       (req.addr_c),
    .mag        (req.mag),
    .full_scale (full_scale_r),
    .duty       (duty_c)
  );

  // Valid and motor select follow the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LANE_LAT-2:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= {sel_r[LANE_LAT-2:0], req.sel};
  end

  // Left motor takes the phases in reverse order
  always_comb begin
    out_valid            = v_r[LANE_LAT-1];
    out_data.duty_second = duty_b;
    if (sel_r[LANE_LAT-1]) begin
      out_data.duty_first = duty_a;
      out_data.duty_third = duty_c;
    end else begin
      out_data.duty_first = duty_c;
      out_data.duty_third = duty_a;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted item produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching item");

  a_duty_below_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.duty_first < full_scale_r || out_data.duty_first == '0) &&
                   (out_data.duty_second < full_scale_r || out_data.duty_second == '0) &&
                   (out_data.duty_third < full_scale_r || out_data.duty_third == '0)))
    else $error("duty above full scale minus one");

endmodule

// ----- rtl/scm_front.sv -----
// ----------------------------------------------------------------------------
// scm_front
// Torque clip and electrical index: two pipeline stages producing the three
// phase table addresses and the torque magnitude.
// ----------------------------------------------------------------------------
module scm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  scm_pkg::in_item_t           in_item,
  input  logic [scm_pkg::POLE_W-1:0]  pole_count,
  input  logic [scm_pkg::FS_W-1:0]    full_scale,
  output logic                        req_valid,
  output scm_pkg::ph_req_t            req
);

  localparam int WIDE_W = scm_pkg::IDX_SHIFT + scm_pkg::AP_W + scm_pkg::IDX_W;

  logic                          v1_r;
  logic [scm_pkg::AP_W-1:0]      ap_r;
  logic [scm_pkg::FS_W-1:0]      mag_r;
  logic                          neg_r;
  logic                          sel_r;

  logic                          v2_r;
  scm_pkg::ph_req_t              req_r;

  logic                          t_neg;
  logic [scm_pkg::TORQUE_W-1:0]  t_abs;
  logic [scm_pkg::FS_W-1:0]      mag_nxt;
  logic                          neg_nxt;
  logic [WIDE_W-1:0]             scaled;
  logic [scm_pkg::IDX_W-1:0]     idx;
  logic [scm_pkg::IDX_W-1:0]     base;
  scm_pkg::ph_req_t              req_nxt;

  // Stage 1: saturate torque to +/- full scale, keep sign and magnitude
  always_comb begin
    t_neg   = in_item.torque_command[scm_pkg::TORQUE_W-1];
    t_abs   = t_neg ? (~in_item.torque_command + 1'b1) : in_item.torque_command;
    mag_nxt = (t_abs > {1'b0, full_scale}) ? full_scale : t_abs[scm_pkg::FS_W-1:0];
    // a full scale of zero clips to zero, which counts as non-negative
    neg_nxt = t_neg && (full_scale != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ap_r  <= in_item.shaft_angle * pole_count;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    sel_r <= in_item.motor_select;
  end

  // Stage 2: angle * poles * table size / (2 * encoder counts), wrap, offset
  always_comb begin
    scaled          = {{scm_pkg::IDX_SHIFT{1'b0}}, ap_r, {scm_pkg::IDX_W{1'b0}}};
    idx             = scaled[scm_pkg::IDX_SHIFT +: scm_pkg::IDX_W];
    base            = idx + (neg_r ? scm_pkg::OFFS_NEG : scm_pkg::OFFS_POS);
    req_nxt.addr_a  = base;
    req_nxt.addr_b  = base + scm_pkg::PHASE_B;
    req_nxt.addr_c  = base + scm_pkg::PHASE_C;
    req_nxt.mag     = mag_r;
    req_nxt.sel     = sel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  assign req_valid = v2_r;
  assign req       = req_r;

endmodule

// ----- rtl/scm_phase.sv -----
// ----------------------------------------------------------------------------
// scm_phase
// One phase lane: sine table read, scale by magnitude, clip to the duty
// ceiling. Three register stages.
// ----------------------------------------------------------------------------
module scm_phase (
  input  logic                        clk,
  input  logic [scm_pkg::IDX_W-1:0]   addr,
  input  logic [scm_pkg::FS_W-1:0]    mag,
  input  logic [scm_pkg::FS_W-1:0]    full_scale,
  output logic [scm_pkg::DUTY_W-1:0]  duty
);

  logic signed [scm_pkg::SINE_W-1:0]  sine_r;
  logic [scm_pkg::FS_W-1:0]           mag_r;
  logic [scm_pkg::PROD_W-1:0]         prod_r;
  logic [scm_pkg::DUTY_W-1:0]         duty_r;

  logic [scm_pkg::SINE_W-2:0]         sine_pos;
  logic [scm_pkg::QUOT_W-1:0]         quot;
  logic [scm_pkg::DUTY_W-1:0]         duty_nxt;

  // Stage A: table read
  always_ff @(posedge clk) begin
    sine_r <= scm_pkg::SINE_ROM[addr];
    mag_r  <= mag;
  end

  // Stage B: scale; negative or zero sine gives no drive
  assign sine_pos = (sine_r > 0) ? sine_r[scm_pkg::SINE_W-2:0] : '0;

  always_ff @(posedge clk) begin
    prod_r <= sine_pos * mag_r;
  end

  // Stage C: divide by amplitude, clip to full scale minus one
  always_comb begin
    quot = prod_r[scm_pkg::PROD_W-1:scm_pkg::AMP_SHIFT];
    if (quot == '0) begin
      duty_nxt = '0;
    end else if (quot >= scm_pkg::QUOT_W'(full_scale)) begin
      duty_nxt = full_scale - 1'b1;
    end else begin
      duty_nxt = quot[scm_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    duty_r <= duty_nxt;
  end

  assign duty = duty_r;

endmodule
